// ===== hdl/postfix_stack_evaluator_defines.svh =====
// assertion macros for the postfix stack evaluator checker
// depends on a clk and an arst_n signal in the scope that uses them
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// checked only while out of reset
`define PSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PSE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pst_pkg.sv =====
// shared types and codes for the postfix stack evaluator
// used by the top level, the divider and the checker; no dependencies
package pst_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNDER    = 3'd1,
		ST_OVER     = 3'd2,
		ST_DIVZERO  = 3'd3,
		ST_LEFTOVER = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD2,
		S_RD1,
		S_EXEC,
		S_DIVW,
		S_WB,
		S_FIN,
		S_FIN_DAT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

endpackage

// ===== hdl/pst_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module pst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/pst_div.sv =====
// iterative signed truncating divider, one quotient bit per cycle
// depends on pst_pkg; divisor must be nonzero when start is raised
module pst_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pst_pkg::div_req_t         req,
	output logic                      done,
	output logic [pst_pkg::DATA_W-1:0] quotient
);

	localparam int W  = pst_pkg::DATA_W;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  mb_q;

	logic [W:0]    rem_sh;
	logic [W:0]    diff;
	logic          na;
	logic          nb;

	assign na     = req.dividend[W-1];
	assign nb     = req.divisor[W-1];
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= na ^ nb;
			rem_q <= '0;
			quo_q <= na ? (W'(0) - req.dividend) : req.dividend;
			mb_q  <= nb ? (W'(0) - req.divisor) : req.divisor;
		end else if (busy_q) begin
			// restoring step on magnitudes
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

// ===== hdl/postfix_stack_evaluator.sv =====
// postfix stack evaluator top level: token stream in, one result per expression out
// depends on pst_pkg, pst_ram and pst_div
//
// usage:
//   s_* takes one parsed postfix token per transfer. s_tuser is the token kind
//   (0 operand, 1 operator), s_tdata carries the operand value and operator code,
//   s_tlast marks the final token of an expression.
//   m_* gives one result per expression (final value and status) after the
//   token with s_tlast has been processed; other tokens give no result.
// sequencing:
//   operand push: ready again the next cycle.
//   add, subtract, multiply: two stack reads through the registered ram
//   read port, then execute and write back.
//   divide: waits for the 32-step iterative divider before write back.
//   a last token adds the top read (skipped on an error or an empty stack) and the output load.
// reset: stack count and error clear, output goes invalid; stack ram contents
//   are not cleared and are only read below the count.
// stall: a result waits in the output register while the next expression's
//   tokens are taken; the block only holds in its output step when a second
//   result is ready before the first has been transferred.
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] operand_value, [33:32] operator_code, rest zero
	input  logic        s_tlast,   // last_token
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] final_value, [34:32] status, rest zero
);

	localparam int W  = pst_pkg::DATA_W;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	pst_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	pst_pkg::status_t err_q, err_d;
	logic             m_valid_q, m_valid_d;

	pst_pkg::op_t     op_q, op_d;
	logic             last_q, last_d;
	logic [W-1:0]     second_q, second_d;
	logic [W-1:0]     first_q, first_d;
	logic [W-1:0]     result_q, result_d;
	logic [W-1:0]     fin_val_q, fin_val_d;
	pst_pkg::status_t fin_st_q, fin_st_d;
	logic [W-1:0]     m_val_q, m_val_d;
	pst_pkg::status_t m_st_q, m_st_d;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [W-1:0]     ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [W-1:0]     ram_rdata;

	pst_pkg::div_req_t div_req;
	logic              div_done;
	logic [W-1:0]      div_quo;

	logic [CW-1:0]    cnt_m1;
	logic [CW-1:0]    cnt_m2;
	logic [2*W-1:0]   product;

	assign cnt_m1  = count_q - CW'(1);
	assign cnt_m2  = count_q - CW'(2);
	assign product = first_q * second_q;

	pst_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pst_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		err_d     = err_q;
		m_valid_d = m_valid_q;
		op_d      = op_q;
		last_d    = last_q;
		second_d  = second_q;
		first_d   = first_q;
		result_d  = result_q;
		fin_val_d = fin_val_q;
		fin_st_d  = fin_st_q;
		m_val_d   = m_val_q;
		m_st_d    = m_st_q;

		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = s_tdata[W-1:0];
		ram_raddr = cnt_m1[AW-1:0];

		div_req.start    = 1'b0;
		div_req.dividend = first_q;
		div_req.divisor  = second_q;

		s_tready = (state_q == pst_pkg::S_IDLE);

		if (m_valid_q && m_tready) begin
			m_valid_d = 1'b0;
		end

		unique case (state_q)
			pst_pkg::S_IDLE: begin
				if (s_tvalid) begin
					op_d    = pst_pkg::op_t'(s_tdata[33:32]);
					last_d  = s_tlast;
					state_d = s_tlast ? pst_pkg::S_FIN : pst_pkg::S_IDLE;
					// tokens after an error only wait for the last one
					if (err_q == pst_pkg::ST_OK) begin
						if (!s_tuser) begin
							if (count_q == CW'(STACK_DEPTH)) begin
								err_d = pst_pkg::ST_OVER;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
							end
						end else if (count_q < CW'(2)) begin
							err_d = pst_pkg::ST_UNDER;
						end else begin
							state_d = pst_pkg::S_RD2;
						end
					end
				end
			end
			pst_pkg::S_RD2: begin
				second_d  = ram_rdata;
				ram_raddr = cnt_m2[AW-1:0];
				state_d   = pst_pkg::S_RD1;
			end
			pst_pkg::S_RD1: begin
				first_d = ram_rdata;
				state_d = pst_pkg::S_EXEC;
			end
			pst_pkg::S_EXEC: begin
				state_d = pst_pkg::S_WB;
				case (op_q)
					pst_pkg::OP_ADD: result_d = first_q + second_q;
					pst_pkg::OP_SUB: result_d = first_q - second_q;
					pst_pkg::OP_MUL: result_d = product[W-1:0];
					default: begin
						if (second_q == '0) begin
							// both operands consumed, nothing pushed
							err_d   = pst_pkg::ST_DIVZERO;
							count_d = cnt_m2;
							state_d = last_q ? pst_pkg::S_FIN : pst_pkg::S_IDLE;
						end else begin
							div_req.start = 1'b1;
							state_d       = pst_pkg::S_DIVW;
						end
					end
				endcase
			end
			pst_pkg::S_DIVW: begin
				if (div_done) begin
					result_d = div_quo;
					state_d  = pst_pkg::S_WB;
				end
			end
			pst_pkg::S_WB: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_m2[AW-1:0];
				ram_wdata = result_q;
				count_d   = cnt_m1;
				state_d   = last_q ? pst_pkg::S_FIN : pst_pkg::S_IDLE;
			end
			pst_pkg::S_FIN: begin
				if (err_q != pst_pkg::ST_OK) begin
					fin_val_d = '0;
					fin_st_d  = err_q;
					state_d   = pst_pkg::S_OUT;
				end else if (count_q == '0) begin
					fin_val_d = '0;
					fin_st_d  = pst_pkg::ST_UNDER;
					state_d   = pst_pkg::S_OUT;
				end else begin
					state_d = pst_pkg::S_FIN_DAT;
				end
			end
			pst_pkg::S_FIN_DAT: begin
				fin_val_d = ram_rdata;
				fin_st_d  = (count_q > CW'(1)) ? pst_pkg::ST_LEFTOVER : pst_pkg::ST_OK;
				state_d   = pst_pkg::S_OUT;
			end
			pst_pkg::S_OUT: begin
				if (!m_valid_q || m_tready) begin
					m_valid_d = 1'b1;
					m_val_d   = fin_val_q;
					m_st_d    = fin_st_q;
					count_d   = '0;
					err_d     = pst_pkg::ST_OK;
					state_d   = pst_pkg::S_IDLE;
				end
			end
			default: state_d = pst_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pst_pkg::S_IDLE;
			count_q   <= '0;
			err_q     <= pst_pkg::ST_OK;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			err_q     <= err_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		last_q    <= last_d;
		second_q  <= second_d;
		first_q   <= first_d;
		result_q  <= result_d;
		fin_val_q <= fin_val_d;
		fin_st_q  <= fin_st_d;
		m_val_q   <= m_val_d;
		m_st_q    <= m_st_d;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, m_st_q, m_val_q};

endmodule

// ===== hdl/pst_checker.sv =====
// port-level checks for the postfix stack evaluator, bound to the top level
// depends on postfix_stack_evaluator_defines.svh and pst_pkg
`include "postfix_stack_evaluator_defines.svh"

module pst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// a stalled result keeps its value
	`PSE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	`PSE_ASSERT(a_status_range, m_tvalid |-> m_tdata[34:32] <= pst_pkg::ST_LEFTOVER, "status code out of range")

	// fault statuses carry a zero value
	`PSE_ASSERT(a_fault_zero, m_tvalid && (m_tdata[34:32] == pst_pkg::ST_UNDER || m_tdata[34:32] == pst_pkg::ST_OVER || m_tdata[34:32] == pst_pkg::ST_DIVZERO) |-> m_tdata[31:0] == '0, "fault result with nonzero value")

	`PSE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result valid during reset")

	// a result does not rise directly after a last-token transfer
	`PSE_ASSERT(a_no_early_result, $rose(m_tvalid) |-> !$past(s_tvalid && s_tready && s_tlast), "result too soon after last token")

endmodule

bind postfix_stack_evaluator pst_checker u_pst_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
